// ----- hw/rtl/rif_pkg.sv -----
// ----------------------------------------------------------------------------
// rif_pkg
// Shared constants for the radical inverse fraction block.
// ----------------------------------------------------------------------------
package rif_pkg;

  localparam int INDEX_WIDTH_DEF = 32;
  localparam int RADIX_WIDTH_DEF = 8;
  localparam int COORD_WIDTH     = 32;
  localparam int RADIX_RESET     = 2;
  localparam int RADIX_MIN       = 2;

endpackage

// ----- hw/rtl/radical_inverse_fraction.sv -----
// ----------------------------------------------------------------------------
// radical_inverse_fraction
// Van der Corput radical inverse of a sample index in a configurable base,
// given as an unsigned 0.32 fraction.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | s_tdata: sample_index
//  m_*      | out       | m_tvalid/m_tready  | m_tdata: coordinate
//  cfg_*    | in        | cfg_we             | cfg_wdata: radix
//
// One item enters per cycle while s_tready is high; the pipeline has two stages
// per base digit, one fold stage and one stage per quotient bit.
// The whole pipeline holds while m_tvalid is high and m_tready low.
// After reset and after each radix write, a bit-serial divider computes the
// reciprocal of the radix; s_tready stays low while it runs.
// Reset sets the radix to 2; radix values 0 and 1 act as 2.
// ----------------------------------------------------------------------------
module radical_inverse_fraction
  import rif_pkg::*;
#(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
  parameter int RADIX_WIDTH = RADIX_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [INDEX_WIDTH-1:0] sample_index, rest zero
  input  logic [((INDEX_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [31:0] coordinate
  output logic [COORD_WIDTH-1:0]                m_tdata,
  input  logic                                  cfg_we,
  input  logic [RADIX_WIDTH-1:0]                cfg_wdata
);

  localparam int IW  = INDEX_WIDTH;
  localparam int RW  = RADIX_WIDTH;
  localparam int DW  = IW + RW;
  localparam int MW  = DW + RW;
  localparam int QW  = IW + RW;
  localparam int CNW = $clog2(IW + 1);
  localparam int CW  = COORD_WIDTH;

  // radix register and reciprocal unit
  logic [RW-1:0]  radix;
  logic [RW-1:0]  b_eff;
  logic [IW-1:0]  recip;
  logic [RW-1:0]  rr;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [RW:0]    rt;
  logic           rge;

  assign b_eff = (radix < RW'(RADIX_MIN)) ? RW'(RADIX_MIN) : radix;
  assign rt    = {rr, (cnt == '0)};
  assign rge   = rt >= {1'b0, b_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RW'(RADIX_RESET);
      busy  <= 1'b1;
      cnt   <= '0;
      rr    <= '0;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
      busy  <= 1'b1;
      cnt   <= '0;
      rr    <= '0;
    end else if (busy) begin
      rr    <= rge ? RW'(rt - {1'b0, b_eff}) : rt[RW-1:0];
      recip <= {recip[IW-2:0], rge};
      cnt   <= cnt + 1'b1;
      if (cnt == CNW'(IW)) begin
        busy <= 1'b0;
      end
    end
  end

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !busy;

  // digit pipeline: stage A multiplies by the reciprocal, stage B corrects
  logic [IW-1:0]   a_a   [IW];
  logic [2*IW-1:0] p_a   [IW];
  logic [DW-1:0]   rev_a [IW];
  logic [DW-1:0]   den_a [IW];
  logic            va    [IW];
  logic [IW-1:0]   a_b   [IW];
  logic [DW-1:0]   rev_b [IW];
  logic [DW-1:0]   den_b [IW];
  logic [RW-1:0]   dig_b [IW];
  logic            dv_b  [IW];
  logic            vb    [IW];

  for (genvar gi = 0; gi < IW; gi++) begin : g_dig
    logic [IW-1:0] a_in;
    logic [DW-1:0] rev_in;
    logic [DW-1:0] den_in;
    logic [RW-1:0] dig_in;
    logic          dv_in;
    logic          v_in;
    logic [MW-1:0] rev_mul;
    logic [MW-1:0] den_mul;
    logic [IW-1:0] q_est;
    logic [QW-1:0] r_est;
    logic          fix;

    if (gi == 0) begin : g_first
      assign a_in   = s_tdata[IW-1:0];
      assign rev_in = '0;
      assign den_in = DW'(1);
      assign dig_in = '0;
      assign dv_in  = 1'b0;
      assign v_in   = s_tvalid && s_tready;
    end else begin : g_next
      assign a_in   = a_b[gi-1];
      assign rev_in = rev_b[gi-1];
      assign den_in = den_b[gi-1];
      assign dig_in = dig_b[gi-1];
      assign dv_in  = dv_b[gi-1];
      assign v_in   = vb[gi-1];
    end

    assign rev_mul = MW'(rev_in) * MW'(b_eff) + MW'(dig_in);
    assign den_mul = MW'(den_in) * MW'(b_eff);

    always_ff @(posedge clk) begin
      if (rst) begin
        va[gi] <= 1'b0;
      end else if (en) begin
        va[gi] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_a[gi]   <= a_in;
        p_a[gi]   <= (2*IW)'(a_in) * (2*IW)'(recip);
        rev_a[gi] <= dv_in ? rev_mul[DW-1:0] : rev_in;
        den_a[gi] <= dv_in ? den_mul[DW-1:0] : den_in;
      end
    end

    // estimate is low by at most one
    assign q_est = p_a[gi][2*IW-1:IW];
    assign r_est = QW'(a_a[gi]) - QW'(q_est) * QW'(b_eff);
    assign fix   = r_est >= QW'(b_eff);

    always_ff @(posedge clk) begin
      if (rst) begin
        vb[gi] <= 1'b0;
      end else if (en) begin
        vb[gi] <= va[gi];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_b[gi]   <= fix ? q_est + 1'b1 : q_est;
        dig_b[gi] <= fix ? RW'(r_est - QW'(b_eff)) : r_est[RW-1:0];
        dv_b[gi]  <= a_a[gi] != '0;
        rev_b[gi] <= rev_a[gi];
        den_b[gi] <= den_a[gi];
      end
    end
  end

  // fold the last digit
  logic [MW-1:0] rev_fm;
  logic [MW-1:0] den_fm;
  logic [DW-1:0] rev_f;
  logic [DW-1:0] den_f;
  logic          vf;

  assign rev_fm = MW'(rev_b[IW-1]) * MW'(b_eff) + MW'(dig_b[IW-1]);
  assign den_fm = MW'(den_b[IW-1]) * MW'(b_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vb[IW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rev_f <= dv_b[IW-1] ? rev_fm[DW-1:0] : rev_b[IW-1];
      den_f <= dv_b[IW-1] ? den_fm[DW-1:0] : den_b[IW-1];
    end
  end

  // restoring division, one quotient bit per stage
  logic [DW-1:0] rem_d [CW];
  logic [DW-1:0] den_d [CW];
  logic [CW-1:0] quo_d [CW];
  logic          vd    [CW];

  for (genvar gj = 0; gj < CW; gj++) begin : g_div
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dd_in;
    logic [CW-1:0] quo_in;
    logic          v_in;
    logic [DW:0]   t;
    logic          ge;

    if (gj == 0) begin : g_first
      assign rem_in = rev_f;
      assign dd_in  = den_f;
      assign quo_in = '0;
      assign v_in   = vf;
    end else begin : g_next
      assign rem_in = rem_d[gj-1];
      assign dd_in  = den_d[gj-1];
      assign quo_in = quo_d[gj-1];
      assign v_in   = vd[gj-1];
    end

    assign t  = {rem_in, 1'b0};
    assign ge = t >= {1'b0, dd_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[gj] <= 1'b0;
      end else if (en) begin
        vd[gj] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_d[gj] <= ge ? DW'(t - {1'b0, dd_in}) : t[DW-1:0];
        den_d[gj] <= dd_in;
        quo_d[gj] <= {quo_in[CW-2:0], ge};
      end
    end
  end

  assign m_tvalid = vd[CW-1];
  assign m_tdata  = quo_d[CW-1];

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radical inverse fraction testbench
// Streams sample indexes into the block under several radix settings and
// checks every coordinate against a digit-reversal predictor with exact
// long division. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rif_pkg::*;

  localparam int LATENCY = 2 * INDEX_WIDTH_DEF + 1 + 32;

  class coord_scoreboard;
    logic [31:0] pending[$];
    int errors;
    int checked;

    function logic [31:0] expected_coord(logic [31:0] idx, logic [7:0] radix_reg);
      logic [63:0] base;
      logic [63:0] rest;
      logic [63:0] rev;
      logic [63:0] den;
      logic [63:0] rem;
      logic [31:0] q;
      base = (radix_reg < 8'(RADIX_MIN)) ? 64'(RADIX_MIN) : 64'(radix_reg);
      rest = 64'(idx);
      rev = '0;
      den = 64'd1;
      while (rest != 0) begin
        rev = rev * base + rest % base;
        den = den * base;
        rest = rest / base;
      end
      rem = rev;
      q = '0;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void note_request(logic [31:0] idx, logic [7:0] radix_reg);
      pending.push_back(expected_coord(idx, radix_reg));
    endfunction

    function void check_coordinate(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $error("coordinate: unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $error("coordinate: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  coord_scoreboard board = new();
  logic [7:0] radix_now = 8'(RADIX_RESET);
  bit stall_on = 1'b1;
  int sent;
  int hold_left = 0;

  radical_inverse_fraction DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random back-pressure, short and long, checks on each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_coordinate(m_tdata);
      if (!stall_on) begin
        m_tready <= 1'b1;
      end else if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left = hold_left - 1;
      end else if ($urandom_range(0, 99) < 70) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        hold_left = gap_len();
      end
    end
  end

  // s_tvalid stays high after an accept so the next request can follow directly;
  // drop it before any gap.
  task send_index(logic [31:0] idx);
    int g;
    g = stall_on ? gap_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= idx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(idx, radix_now);
    sent++;
  endtask

  task drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task write_radix(logic [7:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    radix_now = value;
  endtask

  function logic [31:0] random_index();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 63);
      1: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  task directed_set();
    send_index(32'h0);
    send_index(32'h1);
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0000);
    send_index(32'h5555_5555);
    send_index(32'hAAAA_AAAA);
    send_index({24'h0, radix_now});
    send_index({24'h0, radix_now} - 32'd1);
  endtask

  initial begin
    logic [7:0] radix_list[7] = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd3, 8'd7, 8'd16};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    directed_set();
    for (int p = 0; p < 7; p++) begin
      write_radix(radix_list[p]);
      directed_set();
      // in the third phase only, hold until the pipeline has emptied once more
      if (p == 2) drain();
      stall_on = (p != 4);
      repeat (180) send_index(random_index());
      stall_on = 1'b1;
    end
    for (int p = 0; p < 3; p++) begin
      write_radix(8'($urandom_range(0, 255)));
      repeat (60) send_index(random_index());
    end
    drain();
    $display("Sent %0d indexes across ten radix settings, extremes 0/1/2/255 included;",
             sent);
    $display("checked %0d coordinates with random idle gaps and stalls.", board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end
endmodule
